// ===== hw/rtl/sps_pkg.sv =====
// sps_pkg: shared types and constants of the solar pump sequencer
// holds state and pump codes, register indexes and the config and result structs
// no dependencies; used by every module of the block
package sps_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned TempW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_INIT    = 3'd0,
    ST_READY   = 3'd1,
    ST_STARTUP = 3'd2,
    ST_RUN     = 3'd3,
    ST_PAUSE   = 3'd4
  } state_t;

  // pump commands
  typedef enum logic [1:0] {
    PUMP_OFF  = 2'd0,
    PUMP_FULL = 2'd1,
    PUMP_PID  = 2'd2
  } pump_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_COLLECTOR_HOT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COLLECTOR_LOW = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TANK_MAX      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INIT_DWELL    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_READY_DWELL   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STARTUP_DWELL = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_RUN_BAD_DWELL = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_PAUSE_DWELL   = 3'd7;

  // reset values of the registers
  localparam logic signed [TempW-1:0] COLLECTOR_HOT_RST = 16'sd960;
  localparam logic signed [TempW-1:0] COLLECTOR_LOW_RST = 16'sd800;
  localparam logic signed [TempW-1:0] TANK_MAX_RST      = 16'sd1280;
  localparam logic [TimeW-1:0] INIT_DWELL_RST    = 32'd30000;
  localparam logic [TimeW-1:0] READY_DWELL_RST   = 32'd10000;
  localparam logic [TimeW-1:0] STARTUP_DWELL_RST = 32'd30000;
  localparam logic [TimeW-1:0] RUN_BAD_DWELL_RST = 32'd10000;
  localparam logic [TimeW-1:0] PAUSE_DWELL_RST   = 32'd240000;

  typedef struct packed {
    logic signed [TempW-1:0] collector_hot_level;
    logic signed [TempW-1:0] collector_low_level;
    logic signed [TempW-1:0] tank_max_level;
    logic [TimeW-1:0]        init_dwell_ms;
    logic [TimeW-1:0]        ready_dwell_ms;
    logic [TimeW-1:0]        startup_dwell_ms;
    logic [TimeW-1:0]        run_bad_dwell_ms;
    logic [TimeW-1:0]        pause_dwell_ms;
  } cfg_t;

  typedef struct packed {
    state_t acted;
    pump_t  pump;
    state_t nxt;
    logic   first;
  } result_t;

endpackage

// ===== hw/rtl/sps_cfg_regs.sv =====
// sps_cfg_regs: configuration register file of the solar pump sequencer
// depends on sps_pkg for register indexes, reset values and cfg_t
module sps_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sps_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sps_pkg::CfgDataW-1:0]  cfg_data,
  output sps_pkg::cfg_t                 cfg
);

  sps_pkg::cfg_t regs;

  // register writes, levels take the low half of the data
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.collector_hot_level <= sps_pkg::COLLECTOR_HOT_RST;
      regs.collector_low_level <= sps_pkg::COLLECTOR_LOW_RST;
      regs.tank_max_level      <= sps_pkg::TANK_MAX_RST;
      regs.init_dwell_ms       <= sps_pkg::INIT_DWELL_RST;
      regs.ready_dwell_ms      <= sps_pkg::READY_DWELL_RST;
      regs.startup_dwell_ms    <= sps_pkg::STARTUP_DWELL_RST;
      regs.run_bad_dwell_ms    <= sps_pkg::RUN_BAD_DWELL_RST;
      regs.pause_dwell_ms      <= sps_pkg::PAUSE_DWELL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sps_pkg::REG_COLLECTOR_HOT: regs.collector_hot_level <= cfg_data[sps_pkg::TempW-1:0];
        sps_pkg::REG_COLLECTOR_LOW: regs.collector_low_level <= cfg_data[sps_pkg::TempW-1:0];
        sps_pkg::REG_TANK_MAX:      regs.tank_max_level      <= cfg_data[sps_pkg::TempW-1:0];
        sps_pkg::REG_INIT_DWELL:    regs.init_dwell_ms       <= cfg_data[sps_pkg::TimeW-1:0];
        sps_pkg::REG_READY_DWELL:   regs.ready_dwell_ms      <= cfg_data[sps_pkg::TimeW-1:0];
        sps_pkg::REG_STARTUP_DWELL: regs.startup_dwell_ms    <= cfg_data[sps_pkg::TimeW-1:0];
        sps_pkg::REG_RUN_BAD_DWELL: regs.run_bad_dwell_ms    <= cfg_data[sps_pkg::TimeW-1:0];
        sps_pkg::REG_PAUSE_DWELL:   regs.pause_dwell_ms      <= cfg_data[sps_pkg::TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== hw/rtl/sps_fsm.sv =====
// sps_fsm: sequencer state, dwell timestamp and announce flag with the tick logic
// depends on sps_pkg for state_t, pump_t, cfg_t and result_t
module sps_fsm (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic [sps_pkg::TimeW-1:0]         now_ms,
  input  logic signed [sps_pkg::TempW-1:0]  collector_temp,
  input  logic signed [sps_pkg::TempW-1:0]  tank_temp,
  input  sps_pkg::cfg_t                     cfg,
  output sps_pkg::result_t                  res
);

  sps_pkg::state_t         state;
  sps_pkg::state_t         state_next;
  logic [sps_pkg::TimeW-1:0] dwell_start;
  logic [sps_pkg::TimeW-1:0] dwell_start_next;
  logic                    announce_pending;

  logic [sps_pkg::TimeW-1:0] elapsed;
  logic signed [sps_pkg::TempW-1:0] hot_level;
  logic signed [sps_pkg::TempW-1:0] low_level;
  logic signed [sps_pkg::TempW-1:0] tank_max;
  sps_pkg::state_t         acted;
  sps_pkg::pump_t          pump;
  logic                    restart;
  logic                    run_good;

  assign hot_level = cfg.collector_hot_level;
  assign low_level = cfg.collector_low_level;
  assign tank_max  = cfg.tank_max_level;

  // wrapping elapsed time since the dwell began
  assign elapsed  = now_ms - dwell_start;
  assign run_good = (collector_temp > low_level) && (tank_temp <= tank_max) &&
                    (tank_temp <= collector_temp);

  // transition rules for one tick
  always_comb begin
    acted      = state;
    state_next = state;
    pump       = sps_pkg::PUMP_OFF;
    restart    = 1'b0;
    case (state)
      sps_pkg::ST_READY: begin
        if (collector_temp < low_level) begin
          state_next = sps_pkg::ST_INIT;
        end else if (tank_temp < tank_max) begin
          if (elapsed > cfg.ready_dwell_ms) state_next = sps_pkg::ST_STARTUP;
        end else begin
          restart = 1'b1;
        end
      end
      sps_pkg::ST_STARTUP: begin
        pump = sps_pkg::PUMP_FULL;
        if (elapsed > cfg.startup_dwell_ms) state_next = sps_pkg::ST_RUN;
      end
      sps_pkg::ST_RUN: begin
        pump = sps_pkg::PUMP_PID;
        if (run_good) begin
          restart = 1'b1;
        end else if (elapsed > cfg.run_bad_dwell_ms) begin
          state_next = sps_pkg::ST_PAUSE;
        end
      end
      sps_pkg::ST_PAUSE: begin
        if (elapsed > cfg.pause_dwell_ms) state_next = sps_pkg::ST_READY;
      end
      default: begin
        acted      = sps_pkg::ST_INIT;
        state_next = sps_pkg::ST_INIT;
        if (collector_temp > hot_level) begin
          if (elapsed > cfg.init_dwell_ms) state_next = sps_pkg::ST_READY;
        end else begin
          restart = 1'b1;
        end
      end
    endcase
    dwell_start_next = (restart || (state_next != acted)) ? now_ms : dwell_start;
  end

  // result of this tick
  always_comb begin
    res.acted = acted;
    res.pump  = pump;
    res.nxt   = state_next;
    res.first = announce_pending;
  end

  // state update on each processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= sps_pkg::ST_INIT;
      dwell_start      <= '0;
      announce_pending <= 1'b1;
    end else if (advance) begin
      state            <= state_next;
      dwell_start      <= dwell_start_next;
      announce_pending <= (state_next != acted);
    end
  end

  // a state change announces the new state on the next tick
  a_change_announces: assert property (@(posedge clk) disable iff (rst)
    advance && (state_next != acted) |=> announce_pending)
    else $error("state change did not set announce flag");

  // a state change restarts the dwell at the tick's timestamp
  a_change_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && (state_next != acted) |=> dwell_start == $past(now_ms))
    else $error("state change did not restart dwell");

  // without a tick the sequencer holds
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state) && $stable(dwell_start) && $stable(announce_pending))
    else $error("sequencer state moved without a tick");

endmodule

// ===== hw/rtl/solar_pump_sequencer.sv =====
// solar_pump_sequencer: top level with input and result registers around the tick logic
// depends on sps_pkg, sps_cfg_regs and sps_fsm
//
// usage:
//   input channel (in_valid / in_stall) carries one evaluation tick per transaction:
//   now_ms, collector_temp and tank_temp. output channel (out_valid / out_stall)
//   returns one result per tick: acted_state, pump_mode, next_state, first_tick.
//   a transaction completes at a rising edge with valid high and stall low.
//   a tick accepted into the input register passes through the tick logic into
//   the result register, which drives the outputs.
//   throughput: one tick per cycle while the receiver does not stall.
//   when the receiver stalls, the result register holds its value and the input
//   register keeps one more tick; in_stall rises only once both are full.
//   configuration: cfg_we with cfg_index and cfg_data writes one
//   register; write only while no tick is in flight.
//   reset (rst, synchronous): both registers empty, sequencer in init with its
//   dwell start at zero and the first result flagged as first tick; registers
//   return to their default levels and dwell times.
module solar_pump_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sps_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [sps_pkg::CfgDataW-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sps_pkg::TimeW-1:0]         now_ms,
  input  logic signed [sps_pkg::TempW-1:0]  collector_temp,
  input  logic signed [sps_pkg::TempW-1:0]  tank_temp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        acted_state,
  output logic [1:0]                        pump_mode,
  output logic [2:0]                        next_state,
  output logic                              first_tick
);

  sps_pkg::cfg_t    cfg;
  sps_pkg::result_t tick_res;
  sps_pkg::result_t res_reg;

  logic                              in_reg_valid;
  logic [sps_pkg::TimeW-1:0]         in_now;
  logic signed [sps_pkg::TempW-1:0]  in_collector;
  logic signed [sps_pkg::TempW-1:0]  in_tank;
  logic                              out_free;
  logic                              advance;
  logic                              in_take;

  // handshake control
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_reg_valid && out_free;
  assign in_stall = in_reg_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  sps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sps_fsm u_fsm (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .now_ms         (in_now),
    .collector_temp (in_collector),
    .tank_temp      (in_tank),
    .cfg            (cfg),
    .res            (tick_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_now       <= now_ms;
      in_collector <= collector_temp;
      in_tank      <= tank_temp;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= tick_res;
    end
  end

  assign acted_state = res_reg.acted;
  assign pump_mode   = res_reg.pump;
  assign next_state  = res_reg.nxt;
  assign first_tick  = res_reg.first;

endmodule
